// File: rtl/core/esc_pkg.sv
// shared types, constants and helpers of the environmental sensor compensation pipeline
`default_nettype none

package esc_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEMP    = 3'd0,
      REG_PRESS_A = 3'd1,
      REG_PRESS_B = 3'd2,
      REG_PRESS_C = 3'd3,
      REG_HUM_A   = 3'd4,
      REG_HUM_B   = 3'd5
   } csr_idx_type;

   // divider geometry
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_STAGES = DIV_NUM_W;

   // compensation constants
   localparam logic signed [63:0] PRESS_T_OFFSET = 64'sd128000;
   localparam logic signed [63:0] PRESS_FULL     = 64'sd1048576;
   localparam logic signed [63:0] PRESS_SCALE    = 64'sd3125;
   localparam logic signed [63:0] PRESS_E_BIAS   = 64'sh0000_8000_0000_0000;
   localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
   localparam logic signed [31:0] HUM_MAX        = 32'sd419430400;
   localparam logic signed [31:0] HUM_X_ROUND    = 32'sd16384;
   localparam logic signed [31:0] HUM_BIAS       = 32'sd2097152;
   localparam logic signed [31:0] HUM_Y_BIAS     = 32'sd32768;
   localparam logic signed [31:0] HUM_Y_ROUND    = 32'sd8192;
   localparam logic signed [31:0] TEMP_ROUND     = 32'sd128;

   // decoded calibration coefficients
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic        [7:0]  h1;
      logic signed [15:0] h2;
      logic        [7:0]  h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
   } calib_type;

   // temperature section result
   typedef struct packed {
      logic signed [31:0] t_fine;
      logic signed [31:0] temp;
      logic        [19:0] adc_p;
      logic        [15:0] adc_h;
   } temp_out_type;

   // humidity section result
   typedef struct packed {
      logic signed [31:0] t_fine;
      logic signed [31:0] temp;
      logic        [19:0] adc_p;
      logic        [16:0] humidity;
   } hum_out_type;

   // values that ride along the divider
   typedef struct packed {
      logic signed [31:0] temp;
      logic        [16:0] humidity;
      logic               invalid;
   } press_side_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic                 neg;
      press_side_type       side;
   } div_in_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] quo;
      logic                 neg;
      press_side_type       side;
   } div_out_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic        [31:0] pressure_q8;
      logic        [16:0] humidity_q10;
      logic               pressure_invalid;
   } rsp_type;

   // sign-extend a 16-bit coefficient to the 64-bit pressure datapath
   function automatic logic signed [63:0] sx64(input logic [15:0] v);
      return $signed({{48{v[15]}}, v});
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/esc_req_if.sv
// request channel: one raw conversion triple
`default_nettype none

interface esc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_pressure;
   logic [19:0] raw_temperature;
   logic [15:0] raw_humidity;

   modport source (output valid, output raw_pressure, output raw_temperature,
                   output raw_humidity, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature,
                   input raw_humidity, output ready);
endinterface

`default_nettype wire

// File: rtl/core/esc_rsp_if.sv
// result channel: compensated temperature, pressure and humidity
`default_nettype none

interface esc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic        [31:0] pressure_q8;
   logic        [16:0] humidity_q10;
   logic               pressure_invalid;

   modport source (output valid, output temperature_centi, output pressure_q8,
                   output humidity_q10, output pressure_invalid, input ready);
   modport sink   (input valid, input temperature_centi, input pressure_q8,
                   input humidity_q10, input pressure_invalid, output ready);
endinterface

`default_nettype wire

// File: rtl/core/esc_temp.sv
// temperature compensation pipeline, four stages, produces t_fine and temperature
`default_nettype none

module esc_temp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [19:0]            adc_t,
   input  logic [19:0]            adc_p,
   input  logic [15:0]            adc_h,
   input  esc_pkg::calib_type     calib,
   output logic                   out_valid,
   output esc_pkg::temp_out_type  out_data
);
   import esc_pkg::*;

   typedef struct packed {
      logic [19:0] adc_p;
      logic [15:0] adc_h;
   } raw_type;

   logic [3:0]         vld_ff;
   raw_type            raw_ff [4];
   logic signed [31:0] t2_w, t3_w, x1_w, d_w;
   logic signed [31:0] m1_in, m1_ff, dd_in, dd_ff;
   logic signed [31:0] v1_in, v1_ff, m2_in, m2_ff;
   logic signed [31:0] tf_in, tf_ff, tf4_ff, temp_in, temp_ff;

   // stage 1: offsets and first products
   always_comb begin
      t2_w  = $signed({{16{calib.t2[15]}}, calib.t2});
      t3_w  = $signed({{16{calib.t3[15]}}, calib.t3});
      x1_w  = $signed({15'd0, adc_t[19:3]}) - $signed({15'd0, calib.t1, 1'b0});
      d_w   = $signed({16'd0, adc_t[19:4]}) - $signed({16'd0, calib.t1});
      m1_in = x1_w * t2_w;
      dd_in = d_w * d_w;
   end

   // stage 2: scale and quadratic term
   always_comb begin
      v1_in = m1_ff >>> 11;
      m2_in = (dd_ff >>> 12) * t3_w;
   end

   // stage 3: fine temperature
   assign tf_in = v1_ff + (m2_ff >>> 14);

   // stage 4: temperature in hundredths
   assign temp_in = ((tf_ff <<< 2) + tf_ff + TEMP_ROUND) >>> 8;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ff[0] <= '{adc_p: adc_p, adc_h: adc_h};
         for (int i = 1; i < 4; i++) begin
            raw_ff[i] <= raw_ff[i-1];
         end
         m1_ff   <= m1_in;
         dd_ff   <= dd_in;
         v1_ff   <= v1_in;
         m2_ff   <= m2_in;
         tf_ff   <= tf_in;
         tf4_ff  <= tf_ff;
         temp_ff <= temp_in;
      end
   end

   assign out_valid       = vld_ff[3];
   assign out_data.t_fine = tf4_ff;
   assign out_data.temp   = temp_ff;
   assign out_data.adc_p  = raw_ff[3].adc_p;
   assign out_data.adc_h  = raw_ff[3].adc_h;

endmodule

`default_nettype wire

// File: rtl/core/esc_hum.sv
// humidity compensation pipeline, nine stages, clamps to the valid range
`default_nettype none

module esc_hum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  esc_pkg::temp_out_type  in_data,
   input  esc_pkg::calib_type     calib,
   output logic                   out_valid,
   output esc_pkg::hum_out_type   out_data
);
   import esc_pkg::*;

   localparam int STAGES = 9;

   logic [STAGES-1:0]  vld_ff;
   temp_out_type       side_ff [STAGES];
   logic signed [31:0] h1_w, h2_w, h3_w, h4_w, h5_w, h6_w, v_w;
   logic signed [31:0] xa_in, xa_ff, h5v_in, h5v_ff, vh6_in, vh6_ff, vh3_in, vh3_ff;
   logic signed [31:0] x2_in, x2_ff, y1_in, y1_ff, y2_in, y2_ff;
   logic signed [31:0] x3_ff, y3_in, y3_ff, x4_ff, yh_in, yh_ff, x5_ff, y5_in, y5_ff;
   logic signed [31:0] vv6_in, vv6_ff, s_w, ss_in, ss_ff, vv7_ff, m_in, m_ff, vv8_ff;
   logic signed [31:0] hv_w, hc_w;
   logic [16:0]        hum_in, hum_ff;

   // coefficient widening
   always_comb begin
      h1_w = $signed({24'd0, calib.h1});
      h2_w = $signed({{16{calib.h2[15]}}, calib.h2});
      h3_w = $signed({24'd0, calib.h3});
      h4_w = $signed({{20{calib.h4[11]}}, calib.h4});
      h5_w = $signed({{20{calib.h5[11]}}, calib.h5});
      h6_w = $signed({{24{calib.h6[7]}}, calib.h6});
   end

   // stage 1: temperature offset and products on it
   always_comb begin
      v_w    = in_data.t_fine - HUM_T_OFFSET;
      xa_in  = $signed({2'd0, in_data.adc_h, 14'd0}) - (h4_w <<< 20) + HUM_X_ROUND;
      h5v_in = h5_w * v_w;
      vh6_in = v_w * h6_w;
      vh3_in = v_w * h3_w;
   end

   // stages 2 to 6: x and y terms, their product
   always_comb begin
      x2_in  = (xa_ff - h5v_ff) >>> 15;
      y1_in  = vh6_ff >>> 10;
      y2_in  = (vh3_ff >>> 11) + HUM_Y_BIAS;
      y3_in  = y1_ff * y2_ff;
      yh_in  = ((y3_ff >>> 10) + HUM_BIAS) * h2_w;
      y5_in  = (yh_ff + HUM_Y_ROUND) >>> 14;
      vv6_in = x5_ff * y5_ff;
   end

   // stages 7 to 9: quadratic correction and clamp
   always_comb begin
      s_w   = vv6_ff >>> 15;
      ss_in = s_w * s_w;
      m_in  = (ss_ff >>> 7) * h1_w;
      hv_w  = vv8_ff - (m_ff >>> 4);
      if (hv_w < 0) begin
         hc_w = '0;
      end else if (hv_w > HUM_MAX) begin
         hc_w = HUM_MAX;
      end else begin
         hc_w = hv_w;
      end
      hum_in = hc_w[28:12];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         xa_ff  <= xa_in;
         h5v_ff <= h5v_in;
         vh6_ff <= vh6_in;
         vh3_ff <= vh3_in;
         x2_ff  <= x2_in;
         y1_ff  <= y1_in;
         y2_ff  <= y2_in;
         x3_ff  <= x2_ff;
         y3_ff  <= y3_in;
         x4_ff  <= x3_ff;
         yh_ff  <= yh_in;
         x5_ff  <= x4_ff;
         y5_ff  <= y5_in;
         vv6_ff <= vv6_in;
         vv7_ff <= vv6_ff;
         ss_ff  <= ss_in;
         vv8_ff <= vv7_ff;
         m_ff   <= m_in;
         hum_ff <= hum_in;
      end
   end

   assign out_valid         = vld_ff[STAGES-1];
   assign out_data.t_fine   = side_ff[STAGES-1].t_fine;
   assign out_data.temp     = side_ff[STAGES-1].temp;
   assign out_data.adc_p    = side_ff[STAGES-1].adc_p;
   assign out_data.humidity = hum_ff;

endmodule

`default_nettype wire

// File: rtl/core/esc_press_pre.sv
// pressure front end, six stages: builds dividend and divisor magnitudes
`default_nettype none

module esc_press_pre (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  esc_pkg::hum_out_type  in_data,
   input  esc_pkg::calib_type    calib,
   output logic                  out_valid,
   output esc_pkg::div_in_type   out_data
);
   import esc_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0]  vld_ff;
   hum_out_type        side_ff [STAGES];
   logic signed [63:0] a_w, pf_w, esh_w;
   logic signed [63:0] a2_in, a2_ff, ap5_in, ap5_ff, ap2_in, ap2_ff;
   logic signed [63:0] bp6_in, bp6_ff, c3_in, c3_ff, ap5b_ff, ap2b_ff;
   logic signed [63:0] b_in, b_ff, asum_in, asum_ff;
   logic signed [63:0] e_in, e_ff, np_in, np_ff, num_in, num_ff;
   logic signed [31:0] den_in, den_ff;
   logic [DIV_NUM_W-1:0] mn_w;
   logic [DIV_DEN_W-1:0] md_w;

   // stage 1: offset and first products
   always_comb begin
      a_w    = $signed({{32{in_data.t_fine[31]}}, in_data.t_fine}) - PRESS_T_OFFSET;
      a2_in  = a_w * a_w;
      ap5_in = a_w * sx64(calib.p5);
      ap2_in = a_w * sx64(calib.p2);
   end

   // stages 2 and 3: polynomial terms
   always_comb begin
      bp6_in  = a2_ff * sx64(calib.p6);
      c3_in   = a2_ff * sx64(calib.p3);
      b_in    = bp6_ff + (ap5b_ff <<< 17) + (sx64(calib.p4) <<< 35);
      asum_in = (c3_ff >>> 8) + (ap2b_ff <<< 12);
   end

   // stages 4 and 5: divisor and dividend
   always_comb begin
      e_in   = (PRESS_E_BIAS + asum_ff) * $signed({48'd0, calib.p1});
      pf_w   = PRESS_FULL - $signed({44'd0, side_ff[2].adc_p});
      np_in  = (pf_w <<< 31) - b_ff;
      num_in = np_ff * PRESS_SCALE;
      esh_w  = e_ff >>> 33;
      den_in = $signed(esh_w[31:0]);
   end

   // stage 6: magnitudes for the unsigned divider
   always_comb begin
      mn_w = num_ff[63] ? 64'(-num_ff) : num_ff;
      md_w = den_ff[31] ? 32'(-den_ff) : den_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         a2_ff   <= a2_in;
         ap5_ff  <= ap5_in;
         ap2_ff  <= ap2_in;
         bp6_ff  <= bp6_in;
         c3_ff   <= c3_in;
         ap5b_ff <= ap5_ff;
         ap2b_ff <= ap2_ff;
         b_ff    <= b_in;
         asum_ff <= asum_in;
         e_ff    <= e_in;
         np_ff   <= np_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
         out_data.num           <= mn_w;
         out_data.den           <= md_w;
         out_data.neg           <= num_ff[63] ^ den_ff[31];
         out_data.side.temp     <= side_ff[4].temp;
         out_data.side.humidity <= side_ff[4].humidity;
         out_data.side.invalid  <= (den_ff == '0);
      end
   end

   assign out_valid = vld_ff[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/esc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module esc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  esc_pkg::div_in_type   in_data,
   output logic                  out_valid,
   output esc_pkg::div_out_type  out_data
);
   import esc_pkg::*;

   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] nq;
      logic [DIV_DEN_W-1:0] den;
      logic                 neg;
      press_side_type       side;
   } stage_type;

   logic [DIV_STAGES-1:0] vld_ff;
   stage_type             st_ff [DIV_STAGES];
   stage_type             st_in [DIV_STAGES];
   stage_type             src;
   logic [DIV_DEN_W:0]    trial;
   logic                  ge;

   // one trial subtraction per stage; dividend shifts out, quotient shifts in
   always_comb begin
      src   = '0;
      trial = '0;
      ge    = 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            src.rem  = '0;
            src.nq   = in_data.num;
            src.den  = in_data.den;
            src.neg  = in_data.neg;
            src.side = in_data.side;
         end else begin
            src = st_ff[k-1];
         end
         trial        = {src.rem, src.nq[DIV_NUM_W-1]};
         ge           = (trial >= {1'b0, src.den});
         st_in[k]     = src;
         st_in[k].rem = ge ? DIV_DEN_W'(trial - {1'b0, src.den}) : trial[DIV_DEN_W-1:0];
         st_in[k].nq  = {src.nq[DIV_NUM_W-2:0], ge};
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid     = vld_ff[DIV_STAGES-1];
   assign out_data.quo  = st_ff[DIV_STAGES-1].nq;
   assign out_data.neg  = st_ff[DIV_STAGES-1].neg;
   assign out_data.side = st_ff[DIV_STAGES-1].side;

endmodule

`default_nettype wire

// File: rtl/core/esc_press_post.sv
// pressure back end, five stages: sign fix and second-order correction
`default_nettype none

module esc_press_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  esc_pkg::div_out_type  in_data,
   input  esc_pkg::calib_type    calib,
   output logic                  out_valid,
   output esc_pkg::rsp_type      out_data
);
   import esc_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0]  vld_ff;
   press_side_type     side_ff [STAGES];
   logic signed [63:0] p1_in, p1_ff, ps_w, ps2_in, ps2_ff, p8p_in, p8p_ff, p2_ff;
   logic signed [63:0] a9_in, a9_ff, p3_ff, p8p3_ff, s_in, s_ff, r_w;
   logic [31:0]        ps_lo_w, ps_hi_w, sq_mid_w;
   logic [63:0]        sq_lo_w;

   // stage arithmetic
   always_comb begin
      p1_in    = in_data.neg ? -$signed(in_data.quo) : $signed(in_data.quo);
      ps_w     = p1_ff >>> 13;
      // square kept to its low 64 bits, built from 32-bit halves
      ps_lo_w  = ps_w[31:0];
      ps_hi_w  = ps_w[63:32];
      sq_lo_w  = {32'd0, ps_lo_w} * {32'd0, ps_lo_w};
      sq_mid_w = ps_hi_w * ps_lo_w;
      ps2_in   = $signed(sq_lo_w + {sq_mid_w[30:0], 33'd0});
      p8p_in   = p1_ff * sx64(calib.p8);
      a9_in    = ps2_ff * sx64(calib.p9);
      s_in     = p3_ff + (a9_ff >>> 25) + (p8p3_ff >>> 19);
      r_w      = (s_ff >>> 8) + (sx64(calib.p7) <<< 4);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data.side;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         p1_ff   <= p1_in;
         ps2_ff  <= ps2_in;
         p8p_ff  <= p8p_in;
         p2_ff   <= p1_ff;
         a9_ff   <= a9_in;
         p3_ff   <= p2_ff;
         p8p3_ff <= p8p_ff;
         s_ff    <= s_in;
         out_data.temperature_centi <= side_ff[3].temp;
         out_data.humidity_q10      <= side_ff[3].humidity;
         out_data.pressure_invalid  <= side_ff[3].invalid;
         out_data.pressure_q8       <= side_ff[3].invalid ? 32'd0 : r_w[31:0];
      end
   end

   assign out_valid = vld_ff[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/env_sensor_compensation.sv
// Sections in order: temperature, humidity, pressure pre, divider, pressure post.
// Throughput: one request per cycle; the whole pipeline advances together and holds
// only while a finished result waits on the response channel.
// The 64-stage divider sets most of the latency.
// Reset: synchronous, active high; clears all valid bits and the calibration registers.
`default_nettype none

module env_sensor_compensation (
   input  logic                            clock,
   input  logic                            reset,
   esc_req_if.sink                         req_bus,
   esc_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [esc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [esc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import esc_pkg::*;

   logic [47:0]  temp_word_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [39:0]  hum_a_ff;
   logic [23:0]  hum_b_ff;
   calib_type    calib;
   logic         adv;
   logic         temp_vld, hum_vld, pre_vld, div_vld, post_vld;
   temp_out_type temp_data;
   hum_out_type  hum_data;
   div_in_type   pre_data;
   div_out_type  div_data;
   rsp_type      post_data, rsp_data_ff;
   logic         rsp_valid_ff;

   // calibration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_word_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
         hum_a_ff     <= '0;
         hum_b_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            REG_TEMP:    temp_word_ff <= csr_wdata;
            REG_PRESS_A: press_a_ff   <= csr_wdata;
            REG_PRESS_B: press_b_ff   <= csr_wdata;
            REG_PRESS_C: press_c_ff   <= csr_wdata;
            REG_HUM_A:   hum_a_ff     <= csr_wdata[39:0];
            REG_HUM_B:   hum_b_ff     <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // coefficient unpacking
   always_comb begin
      calib.t1 = temp_word_ff[15:0];
      calib.t2 = $signed(temp_word_ff[31:16]);
      calib.t3 = $signed(temp_word_ff[47:32]);
      calib.p1 = press_a_ff[15:0];
      calib.p2 = $signed(press_a_ff[31:16]);
      calib.p3 = $signed(press_a_ff[47:32]);
      calib.p4 = $signed(press_b_ff[15:0]);
      calib.p5 = $signed(press_b_ff[31:16]);
      calib.p6 = $signed(press_b_ff[47:32]);
      calib.p7 = $signed(press_c_ff[15:0]);
      calib.p8 = $signed(press_c_ff[31:16]);
      calib.p9 = $signed(press_c_ff[47:32]);
      calib.h1 = hum_a_ff[7:0];
      calib.h2 = $signed(hum_a_ff[23:8]);
      calib.h3 = hum_a_ff[31:24];
      calib.h6 = $signed(hum_a_ff[39:32]);
      calib.h4 = $signed(hum_b_ff[11:0]);
      calib.h5 = $signed(hum_b_ff[23:12]);
   end

   // pipeline moves whenever the output register is free or being emptied
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   esc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .adc_t     (req_bus.raw_temperature),
      .adc_p     (req_bus.raw_pressure),
      .adc_h     (req_bus.raw_humidity),
      .calib     (calib),
      .out_valid (temp_vld),
      .out_data  (temp_data)
   );

   esc_hum u_hum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (temp_vld),
      .in_data   (temp_data),
      .calib     (calib),
      .out_valid (hum_vld),
      .out_data  (hum_data)
   );

   esc_press_pre u_press_pre (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (hum_vld),
      .in_data   (hum_data),
      .calib     (calib),
      .out_valid (pre_vld),
      .out_data  (pre_data)
   );

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pre_vld),
      .in_data   (pre_data),
      .out_valid (div_vld),
      .out_data  (div_data)
   );

   esc_press_post u_press_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_vld),
      .in_data   (div_data),
      .calib     (calib),
      .out_valid (post_vld),
      .out_data  (post_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= post_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= post_data;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.temperature_centi = rsp_data_ff.temperature_centi;
   assign rsp_bus.pressure_q8       = rsp_data_ff.pressure_q8;
   assign rsp_bus.humidity_q10      = rsp_data_ff.humidity_q10;
   assign rsp_bus.pressure_invalid  = rsp_data_ff.pressure_invalid;

   // checks
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pressure_invalid |-> rsp_data_ff.pressure_q8 == 32'd0)
      else $error("flagged pressure is not zero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.humidity_q10 <= 17'd102400)
      else $error("humidity out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(post_vld) && $stable(rsp_valid_ff))
      else $error("pipeline moved during stall");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule

`default_nettype wire
